// ===== src/rtbl_pkg.sv =====
`default_nettype none
package rtbl_pkg;

  localparam int HOST_W = 16;
  // stored cost is wide enough for any unreachable limit in range
  localparam int COST_W = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_ADV   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_KEPT     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;
  localparam logic [2:0] ST_BADINDEX = 3'd5;

  typedef enum logic [2:0] {
    M_NONE,
    M_CLEAR,
    M_SEARCH,
    M_SHIFT,
    M_READ,
    M_DONE
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [HOST_W-1:0] dst;
    logic [HOST_W-1:0] next;
    logic [COST_W-1:0] cost;
  } entry_t;

  // transaction token walking down the cell row
  typedef struct packed {
    mode_t             mode;
    logic              is_adv;
    logic              full;
    entry_t            item;
    logic [HOST_W-1:0] sender;
    entry_t            carry;
    logic [2:0]        status;
    entry_t            res;
  } tok_t;

endpackage
`default_nettype wire

// ===== src/distance_vector_route_table_top.sv =====
`default_nettype none
// Sorted distance-vector route table held in a row of TABLE_DEPTH cells, one
// route per cell. Every transaction is turned into a token that walks the row
// one cell per clock; each cell compares, replaces, inserts, shifts or reads its
// own entry as the token passes. A read with an out-of-range index makes no
// token and skips the cell row.
// One transaction is in flight at a time; a new one is accepted while the
// previous result still waits at the output. No clearing pass follows reset.
module distance_vector_route_table_top
  import rtbl_pkg::*;
#(
  parameter int TABLE_DEPTH      = 256,
  parameter int UNREACHABLE_COST = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_route_dst,
  input  wire logic [15:0] in_route_next,
  input  wire logic [4:0]  in_route_cost,
  input  wire logic [15:0] in_sender,
  input  wire logic [7:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_position,
  output logic [15:0]      out_entry_dst,
  output logic [15:0]      out_entry_next,
  output logic [4:0]       out_entry_cost,
  output logic [8:0]       out_entry_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int IW = CW + 8;
  localparam logic [COST_W-1:0] UNREACH = COST_W'(UNREACHABLE_COST);

  tok_t          tok_c [0:TABLE_DEPTH];
  logic [CW-1:0] rem_c [0:TABLE_DEPTH];
  logic [PW-1:0] pos_c [0:TABLE_DEPTH];

  state_t        state_r, state_nxt;
  logic [15:0]   host_r;
  logic [CW-1:0] count_r, count_nxt;
  tok_t          launch_r, launch_nxt;
  logic [CW-1:0] launch_rem_r, launch_rem_nxt;

  logic [2:0]    pend_status_r, pend_status_nxt;
  logic [7:0]    pend_pos_r, pend_pos_nxt;
  entry_t        pend_entry_r, pend_entry_nxt;
  logic [CW-1:0] pend_count_r, pend_count_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r;
  logic [7:0]    out_pos_r;
  entry_t        out_entry_r;
  logic [CW-1:0] out_count_r;

  logic          accept, out_load, emerge, bad_index;
  logic [COST_W-1:0] cost_in, cost_raw, cost_adv;

  assign accept    = in_valid && in_ready;
  assign emerge    = tok_c[TABLE_DEPTH].mode != M_NONE;
  assign bad_index = (in_opcode == OP_READ) &&
                     !(IW'(in_read_index) < IW'(count_r));

  // cell row
  assign tok_c[0] = launch_r;
  assign rem_c[0] = launch_rem_r;
  assign pos_c[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtbl_cell #(
      .CW    (CW),
      .PW    (PW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_c[i]),
      .rem_i (rem_c[i]),
      .pos_i (pos_c[i]),
      .tok_o (tok_c[i+1]),
      .rem_o (rem_c[i+1]),
      .pos_o (pos_c[i+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = bad_index ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (emerge) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_DRAIN: out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  assign cost_in  = COST_W'(in_route_cost);
  assign cost_raw = (cost_in > UNREACH) ? UNREACH : cost_in;
  assign cost_adv = (cost_in + COST_W'(1) >= UNREACH) ? UNREACH : cost_in + COST_W'(1);

  // datapath
  always_comb begin
    launch_nxt      = '0;
    launch_nxt.mode = M_NONE;
    launch_rem_nxt  = count_r;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_pos_nxt    = pend_pos_r;
    pend_entry_nxt  = pend_entry_r;
    pend_count_nxt  = pend_count_r;

    if (accept) begin
      launch_nxt.is_adv   = in_opcode == OP_ADV;
      launch_nxt.full     = count_r == CW'(TABLE_DEPTH);
      launch_nxt.item.dst = in_route_dst;
      launch_nxt.sender   = in_sender;
      case (in_opcode)
        OP_CLEAR: begin
          launch_nxt.mode     = M_CLEAR;
          launch_nxt.item.dst = host_r;
          count_nxt           = CW'(1);
        end
        OP_RAW: begin
          launch_nxt.mode      = M_SEARCH;
          launch_nxt.item.next = in_route_next;
          launch_nxt.item.cost = cost_raw;
        end
        OP_ADV: begin
          launch_nxt.mode      = M_SEARCH;
          launch_nxt.item.next = in_sender;
          launch_nxt.item.cost = cost_adv;
        end
        OP_READ: begin
          launch_rem_nxt = CW'(in_read_index);
          if (bad_index) begin
            pend_status_nxt = ST_BADINDEX;
            pend_pos_nxt    = in_read_index;
            pend_entry_nxt  = '0;
            pend_count_nxt  = count_r;
          end else begin
            launch_nxt.mode = M_READ;
          end
        end
        default: begin
        end
      endcase
    end

    if (emerge) begin
      if (tok_c[TABLE_DEPTH].mode == M_SEARCH) begin
        // ran off the end of a full row without a match
        pend_status_nxt = ST_FULL;
        pend_pos_nxt    = '0;
        pend_entry_nxt  = '0;
        pend_count_nxt  = count_r;
      end else begin
        pend_status_nxt = tok_c[TABLE_DEPTH].status;
        pend_pos_nxt    = 8'(pos_c[TABLE_DEPTH]);
        pend_entry_nxt  = tok_c[TABLE_DEPTH].res;
        if (tok_c[TABLE_DEPTH].status == ST_INSERTED) begin
          count_nxt = count_r + CW'(1);
        end
        pend_count_nxt = count_nxt;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    launch_rem_r  <= launch_rem_nxt;
    pend_status_r <= pend_status_nxt;
    pend_pos_r    <= pend_pos_nxt;
    pend_entry_r  <= pend_entry_nxt;
    pend_count_r  <= pend_count_nxt;
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_pos_r    <= pend_pos_r;
      out_entry_r  <= pend_entry_r;
      out_count_r  <= pend_count_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      host_r      <= 16'd1;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        host_r <= cfg_wdata;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_entry_dst   = out_entry_r.dst;
  assign out_entry_next  = out_entry_r.next;
  assign out_entry_cost  = out_entry_r.cost[4:0];
  assign out_entry_count = 9'(out_count_r);

`ifndef ASSERT_OFF
  a_token_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    emerge |-> state_r == S_RUN)
    else $error("token left the cell row outside of a run");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_launch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !bad_index) |=> launch_r.mode != M_NONE && state_r == S_RUN)
    else $error("accepted transaction not launched into the cell row");

  a_drain_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented after drain");
`endif

endmodule
`default_nettype wire

// ===== src/rtbl_cell.sv =====
`default_nettype none
module rtbl_cell
  import rtbl_pkg::*;
#(
  parameter int CW    = 9,
  parameter int PW    = 8,
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tok_t          tok_i,
  input  wire logic [CW-1:0] rem_i,
  input  wire logic [PW-1:0] pos_i,
  output tok_t               tok_o,
  output logic [CW-1:0]      rem_o,
  output logic [PW-1:0]      pos_o
);

  entry_t        entry_r, entry_nxt;
  tok_t          tok_r, tok_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_i;
    pos_nxt   = pos_i;
    rem_nxt   = (rem_i != '0) ? rem_i - CW'(1) : '0;
    case (tok_i.mode)
      M_CLEAR: begin
        entry_nxt      = tok_i.item;
        tok_nxt.res    = tok_i.item;
        tok_nxt.status = ST_DONE;
        tok_nxt.mode   = M_DONE;
        pos_nxt        = PW'(INDEX);
      end
      M_READ: begin
        if (rem_i == '0) begin
          tok_nxt.res    = entry_r;
          tok_nxt.status = ST_DONE;
          tok_nxt.mode   = M_DONE;
          pos_nxt        = PW'(INDEX);
        end
      end
      M_SEARCH: begin
        if (rem_i == '0) begin
          // past the last valid entry: append here
          entry_nxt      = tok_i.item;
          tok_nxt.res    = tok_i.item;
          tok_nxt.status = ST_INSERTED;
          tok_nxt.mode   = M_DONE;
          pos_nxt        = PW'(INDEX);
        end else if (entry_r.dst == tok_i.item.dst) begin
          pos_nxt      = PW'(INDEX);
          tok_nxt.mode = M_DONE;
          if (!tok_i.is_adv || tok_i.item.cost < entry_r.cost ||
              entry_r.next == tok_i.sender) begin
            entry_nxt      = tok_i.item;
            tok_nxt.res    = tok_i.item;
            tok_nxt.status = ST_REPLACED;
          end else begin
            tok_nxt.res    = entry_r;
            tok_nxt.status = ST_KEPT;
          end
        end else if (entry_r.dst > tok_i.item.dst) begin
          if (tok_i.full) begin
            tok_nxt.res    = '0;
            tok_nxt.status = ST_FULL;
            tok_nxt.mode   = M_DONE;
            pos_nxt        = '0;
          end else begin
            // insert here and push the rest one cell down
            entry_nxt      = tok_i.item;
            tok_nxt.carry  = entry_r;
            tok_nxt.res    = tok_i.item;
            tok_nxt.status = ST_INSERTED;
            tok_nxt.mode   = M_SHIFT;
            pos_nxt        = PW'(INDEX);
          end
        end
      end
      M_SHIFT: begin
        entry_nxt = tok_i.carry;
        if (rem_i == '0) begin
          tok_nxt.mode = M_DONE;
        end else begin
          tok_nxt.carry = entry_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rem_r   <= rem_nxt;
    pos_r   <= pos_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign rem_o = rem_r;
  assign pos_o = pos_r;

endmodule
`default_nettype wire
